// ----- hdl/tlpq_pkg.sv -----
// shared types, codes and defaults of the two-level priority queue
package tlpq_pkg;

    // default geometry
    localparam int DEF_DEPTH      = 16;
    localparam int DEF_DATA_WIDTH = 32;

    // port field widths
    localparam int ELEM_W   = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int OUT_USER_W = 4;

    // operation codes carried in the input tuser
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_LO = 2'd0,
        OP_PUSH_HI = 2'd1,
        OP_POP     = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } t_status;

    // output tuser bit positions
    localparam int UB_VALID  = 0;
    localparam int UB_STAT_L = 1;
    localparam int UB_STAT_H = 2;
    localparam int UB_EMPTY  = 3;

endpackage

// ----- hdl/two_level_priority_queue.sv -----
// two-class strict priority queue built on two synchronous ring memories
//
// Usage:
//   Input stream (s side): each word is one operation. tuser carries the
//   operation (push low, push high, pop, clear), tdata the element that a
//   push stores. Output stream (m side): exactly one result word per input
//   word, in order. tdata is the popped element (zero unless a pop
//   succeeded), tuser holds popped_valid, status and queue_empty.
//   Pops return the oldest high-class entry, else the oldest low-class one.
//   Throughput: one operation per cycle while the receiver keeps up. The
//   result is presented on the cycle after the input is accepted, set by
//   the registered read of the class memory that a pop addresses.
//   The result sits in one output register; the input is taken whenever
//   that register is empty or being drained in the same cycle, so a stalled
//   receiver holds the result steady and back-pressures the input.
//   Reset holds s_tready low and clears the indices, fill counts and output
//   valid flag; memory contents are not cleared and need no clearing pass,
//   since only entries covered by a count are ever read.
//   A push to a full class is dropped with status push-full; a pop on an
//   empty queue returns status pop-empty. Clear empties both classes.
module two_level_priority_queue
    import tlpq_pkg::*;
#(
    parameter int DEPTH      = DEF_DEPTH,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [ELEM_W-1:0]     i_s_tdata,   // [31:0] element
    input  logic [OP_W-1:0]       i_s_tuser,   // [1:0] operation
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [ELEM_W-1:0]     o_m_tdata,   // [31:0] popped_element
    output logic [OUT_USER_W-1:0] o_m_tuser    // [0] popped_valid, [2:1] status, [3] queue_empty
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    // class memories
    logic [DATA_WIDTH-1:0] r_hi_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_lo_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_hi_rdata;
    logic [DATA_WIDTH-1:0] r_lo_rdata;

    // ring pointers and fill counts
    logic [IDX_W-1:0] r_hi_rd, n_hi_rd, r_hi_wr, n_hi_wr;
    logic [IDX_W-1:0] r_lo_rd, n_lo_rd, r_lo_wr, n_lo_wr;
    logic [CNT_W-1:0] r_hi_cnt, n_hi_cnt, r_lo_cnt, n_lo_cnt;

    // output register
    logic    r_out_valid;
    logic    r_pop_valid, n_pop_valid;
    logic    r_pop_hi, n_pop_hi;
    t_status r_status, n_status;
    logic    r_empty, n_empty;

    logic                  w_in_acc;
    logic                  w_hi_we, w_lo_we, w_hi_re, w_lo_re;
    t_op                   w_op;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic [DATA_WIDTH-1:0] w_rsel;
    logic [ELEM_W-1:0]     w_pop_word;

    assign o_s_tready = i_rst_n && (!r_out_valid || i_m_tready);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_op       = t_op'(i_s_tuser);

    // element width adaptation between port and memory
    generate
        if (DATA_WIDTH >= ELEM_W) begin : g_wide
            assign w_wdata    = DATA_WIDTH'(i_s_tdata);
            assign w_pop_word = w_rsel[ELEM_W-1:0];
        end else begin : g_narrow
            assign w_wdata    = i_s_tdata[DATA_WIDTH-1:0];
            assign w_pop_word = ELEM_W'(w_rsel);
        end
    endgenerate

    // operation decode and pointer update
    always_comb begin
        n_hi_rd     = r_hi_rd;
        n_hi_wr     = r_hi_wr;
        n_hi_cnt    = r_hi_cnt;
        n_lo_rd     = r_lo_rd;
        n_lo_wr     = r_lo_wr;
        n_lo_cnt    = r_lo_cnt;
        n_pop_valid = 1'b0;
        n_pop_hi    = 1'b0;
        n_status    = ST_OK;
        w_hi_we     = 1'b0;
        w_lo_we     = 1'b0;
        w_hi_re     = 1'b0;
        w_lo_re     = 1'b0;
        case (w_op)
            OP_PUSH_LO: begin
                if (r_lo_cnt == FULL_CNT) begin
                    n_status = ST_PUSH_FULL;
                end else begin
                    w_lo_we  = w_in_acc;
                    n_lo_wr  = (r_lo_wr == LAST_IDX) ? '0 : r_lo_wr + 1'b1;
                    n_lo_cnt = r_lo_cnt + 1'b1;
                end
            end
            OP_PUSH_HI: begin
                if (r_hi_cnt == FULL_CNT) begin
                    n_status = ST_PUSH_FULL;
                end else begin
                    w_hi_we  = w_in_acc;
                    n_hi_wr  = (r_hi_wr == LAST_IDX) ? '0 : r_hi_wr + 1'b1;
                    n_hi_cnt = r_hi_cnt + 1'b1;
                end
            end
            OP_POP: begin
                if (r_hi_cnt != '0) begin
                    w_hi_re     = w_in_acc;
                    n_pop_valid = 1'b1;
                    n_pop_hi    = 1'b1;
                    n_hi_rd     = (r_hi_rd == LAST_IDX) ? '0 : r_hi_rd + 1'b1;
                    n_hi_cnt    = r_hi_cnt - 1'b1;
                end else if (r_lo_cnt != '0) begin
                    w_lo_re     = w_in_acc;
                    n_pop_valid = 1'b1;
                    n_lo_rd     = (r_lo_rd == LAST_IDX) ? '0 : r_lo_rd + 1'b1;
                    n_lo_cnt    = r_lo_cnt - 1'b1;
                end else begin
                    n_status = ST_POP_EMPTY;
                end
            end
            OP_CLEAR: begin
                n_hi_rd  = '0;
                n_hi_wr  = '0;
                n_hi_cnt = '0;
                n_lo_rd  = '0;
                n_lo_wr  = '0;
                n_lo_cnt = '0;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
        n_empty = (n_hi_cnt == '0) && (n_lo_cnt == '0);
    end

    // high class memory: write on push, registered read on pop
    always_ff @(posedge i_clk) begin
        if (w_hi_we) begin
            r_hi_mem[r_hi_wr] <= w_wdata;
        end
        if (w_hi_re) begin
            r_hi_rdata <= r_hi_mem[r_hi_rd];
        end
    end

    // low class memory: write on push, registered read on pop
    always_ff @(posedge i_clk) begin
        if (w_lo_we) begin
            r_lo_mem[r_lo_wr] <= w_wdata;
        end
        if (w_lo_re) begin
            r_lo_rdata <= r_lo_mem[r_lo_rd];
        end
    end

    // pointers, counts and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi_rd     <= '0;
            r_hi_wr     <= '0;
            r_hi_cnt    <= '0;
            r_lo_rd     <= '0;
            r_lo_wr     <= '0;
            r_lo_cnt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_hi_rd     <= n_hi_rd;
                r_hi_wr     <= n_hi_wr;
                r_hi_cnt    <= n_hi_cnt;
                r_lo_rd     <= n_lo_rd;
                r_lo_wr     <= n_lo_wr;
                r_lo_cnt    <= n_lo_cnt;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_pop_valid <= n_pop_valid;
            r_pop_hi    <= n_pop_hi;
            r_status    <= n_status;
            r_empty     <= n_empty;
        end
    end

    // output word
    assign w_rsel     = r_pop_hi ? r_hi_rdata : r_lo_rdata;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_pop_valid ? w_pop_word : '0;
    assign o_m_tuser  = {r_empty, r_status, r_pop_valid};

endmodule

// ----- hdl/tlpq_checker.sv -----
// port-level checker of the two-level priority queue and its bind
module tlpq_checker
    import tlpq_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic [OP_W-1:0]       i_s_tuser,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [ELEM_W-1:0]     o_m_tdata,
    input logic [OUT_USER_W-1:0] o_m_tuser
);

    logic    w_pop_valid;
    logic    w_empty;
    t_status w_status;
    logic    w_in_acc;

    assign w_pop_valid = o_m_tuser[UB_VALID];
    assign w_empty     = o_m_tuser[UB_EMPTY];
    assign w_status    = t_status'(o_m_tuser[UB_STAT_H:UB_STAT_L]);
    assign w_in_acc    = i_s_tvalid && o_s_tready;

    // a stalled result word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser))
        else $error("result word changed while stalled");

    // a popped word always comes with ok status
    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && w_pop_valid |-> w_status == ST_OK)
        else $error("popped word with non-ok status");

    // no popped word means zero data
    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !w_pop_valid |-> o_m_tdata == '0)
        else $error("nonzero data without a pop");

    // pop on empty leaves the queue empty
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && w_status == ST_POP_EMPTY |-> w_empty && !w_pop_valid)
        else $error("pop-empty status on non-empty queue");

    // a clear answers on the next cycle with an empty queue
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_s_tuser == OP_CLEAR |=> o_m_tvalid && w_empty
            && w_status == ST_OK && !w_pop_valid)
        else $error("clear did not report an empty queue");

endmodule

bind two_level_priority_queue tlpq_checker u_tlpq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// ----- dv/testbench.sv -----
// self-checking stream testbench for the two-level priority queue
module testbench;
    import tlpq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W      = $clog2(DEF_DEPTH);
    localparam int CNT_W      = $clog2(DEF_DEPTH + 1);
    localparam int NUM_RANDOM = 1875;
    localparam int IDLE_LIMIT = 1000;

    // one result word, split into its fields
    typedef struct packed {
        logic [ELEM_W-1:0] elem;
        logic              valid;
        t_status           status;
        logic              empty;
    } t_result;

    // one row of the directed table; reps > 1 pushes elem, elem+1, ...
    typedef struct {
        t_op               op;
        logic [ELEM_W-1:0] elem;
        int                reps;
        bit                typed;
        t_result           res;
    } t_row;

    // receiver stall patterns
    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_SPARSE,
        READY_BURSTY
    } t_ready_mode;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [ELEM_W-1:0]     i_s_tdata  = '0;   // [31:0] element
    logic [OP_W-1:0]       i_s_tuser  = '0;   // [1:0] operation
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [ELEM_W-1:0]     o_m_tdata;         // [31:0] popped_element
    logic [OUT_USER_W-1:0] o_m_tuser;         // [0] popped_valid, [2:1] status, [3] queue_empty

    // shadow copy of both class rings
    logic [ELEM_W-1:0] hi_mem [DEF_DEPTH];
    logic [ELEM_W-1:0] lo_mem [DEF_DEPTH];
    logic [IDX_W-1:0]  hi_rd, hi_wr, lo_rd, lo_wr;
    logic [CNT_W-1:0]  hi_cnt, lo_cnt;

    // results of words driven but not yet taken, and of words taken
    t_result staged_results[$];
    t_result due_results[$];

    int          errors     = 0;
    int          result_no  = 0;
    int          idle_count = 0;
    t_ready_mode ready_mode = READY_ALWAYS;
    logic [7:0]  ready_tick = '0;

    t_row directed [6] = '{
        '{OP_POP,     32'h0000_0000, 1,  1'b1, '{'0, 1'b0, ST_POP_EMPTY, 1'b1}},
        '{OP_PUSH_LO, 32'h0000_0000, 1,  1'b1, '{'0, 1'b0, ST_OK, 1'b0}},
        '{OP_PUSH_HI, 32'hFFFF_FFFF, 1,  1'b1, '{'0, 1'b0, ST_OK, 1'b0}},
        '{OP_POP,     32'h1234_5678, 1,  1'b1, '{32'hFFFF_FFFF, 1'b1, ST_OK, 1'b0}},
        '{OP_POP,     32'hFFFF_FFFF, 1,  1'b1, '{'0, 1'b1, ST_OK, 1'b1}},
        '{OP_CLEAR,   32'hDEAD_BEEF, 1,  1'b1, '{'0, 1'b0, ST_OK, 1'b1}}
    };
    t_row fill_rows [4] = '{
        '{OP_PUSH_HI, 32'h8000_0001, 16, 1'b0, '{'0, 1'b0, ST_OK, 1'b0}},
        '{OP_PUSH_HI, 32'h5A5A_5A5A, 1,  1'b1, '{'0, 1'b0, ST_PUSH_FULL, 1'b0}},
        '{OP_POP,     32'h0000_0000, 1,  1'b0, '{'0, 1'b0, ST_OK, 1'b0}},
        '{OP_CLEAR,   32'h0000_0000, 1,  1'b1, '{'0, 1'b0, ST_OK, 1'b1}}
    };

    two_level_priority_queue DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #10 i_clk = ~i_clk;

    // ring index step, wraps at the last slot
    function automatic logic [IDX_W-1:0] next_slot(logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(DEF_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    // apply one operation to the shadow queue and return its result
    function automatic t_result queue_op_result(t_op op, logic [ELEM_W-1:0] elem);
        t_result r;
        r = '{'0, 1'b0, ST_OK, 1'b0};
        case (op)
            OP_PUSH_LO: begin
                if (lo_cnt == CNT_W'(DEF_DEPTH)) begin
                    r.status = ST_PUSH_FULL;
                end else begin
                    lo_mem[lo_wr] = elem;
                    lo_wr = next_slot(lo_wr);
                    lo_cnt = lo_cnt + 1'b1;
                end
            end
            OP_PUSH_HI: begin
                if (hi_cnt == CNT_W'(DEF_DEPTH)) begin
                    r.status = ST_PUSH_FULL;
                end else begin
                    hi_mem[hi_wr] = elem;
                    hi_wr = next_slot(hi_wr);
                    hi_cnt = hi_cnt + 1'b1;
                end
            end
            OP_POP: begin
                // high class drains first
                if (hi_cnt != 0) begin
                    r.elem = hi_mem[hi_rd];
                    r.valid = 1'b1;
                    hi_rd = next_slot(hi_rd);
                    hi_cnt = hi_cnt - 1'b1;
                end else if (lo_cnt != 0) begin
                    r.elem = lo_mem[lo_rd];
                    r.valid = 1'b1;
                    lo_rd = next_slot(lo_rd);
                    lo_cnt = lo_cnt - 1'b1;
                end else begin
                    r.status = ST_POP_EMPTY;
                end
            end
            default: begin
                hi_rd = '0;
                hi_wr = '0;
                hi_cnt = '0;
                lo_rd = '0;
                lo_wr = '0;
                lo_cnt = '0;
            end
        endcase
        r.empty = (hi_cnt == 0) && (lo_cnt == 0);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [ELEM_W-1:0] got,
                                   logic [ELEM_W-1:0] want);
        errors++;
        $display("mismatch in %s at result %0d: got %h, want %h",
                 what, result_no, got, want);
    endtask

    // drive one word and hold it until the queue takes it
    task automatic send_op(t_op op, logic [ELEM_W-1:0] elem, bit typed, t_result typed_res);
        t_result pred;
        pred = queue_op_result(op, elem);
        staged_results.push_back(typed ? typed_res : pred);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= elem;
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // hold off the sender until every outstanding result has come back
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (staged_results.size() != 0 || due_results.size() != 0);
    endtask

    // receiver stalls, pattern changes now and then
    always @(posedge i_clk) begin
        ready_tick <= ready_tick + 1'b1;
        if (ready_tick == '0) begin
            ready_mode <= t_ready_mode'($urandom_range(0, 3));
        end
        case (ready_mode)
            READY_ALWAYS: i_m_tready <= 1'b1;
            READY_RANDOM: i_m_tready <= 1'($urandom_range(0, 1));
            READY_SPARSE: i_m_tready <= (ready_tick[1:0] == 2'd0);
            default:      i_m_tready <= (ready_tick[3:0] < 4'd3);
        endcase
    end

    // compare each result word, then log the word taken at this edge
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got.elem   = o_m_tdata;
                got.valid  = o_m_tuser[UB_VALID];
                got.status = t_status'(o_m_tuser[UB_STAT_H:UB_STAT_L]);
                got.empty  = o_m_tuser[UB_EMPTY];
                if (due_results.size() == 0) begin
                    report_mismatch("unexpected word", got.elem, '0);
                end else begin
                    want = due_results.pop_front();
                    if (got.elem !== want.elem)
                        report_mismatch("popped_element", got.elem, want.elem);
                    if (got.valid !== want.valid)
                        report_mismatch("popped_valid", ELEM_W'(got.valid),
                                        ELEM_W'(want.valid));
                    if (got.status !== want.status)
                        report_mismatch("status", ELEM_W'(got.status),
                                        ELEM_W'(want.status));
                    if (got.empty !== want.empty)
                        report_mismatch("queue_empty", ELEM_W'(got.empty),
                                        ELEM_W'(want.empty));
                end
                result_no++;
            end
            if (i_s_tvalid && o_s_tready && staged_results.size() != 0) begin
                due_results.push_back(staged_results.pop_front());
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_count <= 0;
        end else if (idle_count >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    // stimulus
    initial begin
        int   burst_left;
        int   gap;
        int   push_pct;
        int   hi_pct;
        int   roll;
        t_op  op;
        logic [ELEM_W-1:0] elem;

        burst_left = 0;
        push_pct = 50;
        hi_pct = 50;
        hi_rd = '0;
        hi_wr = '0;
        hi_cnt = '0;
        lo_rd = '0;
        lo_wr = '0;
        lo_cnt = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty pop, extremes, priority order, clear, high class full
        foreach (directed[r]) begin
            send_op(directed[r].op, directed[r].elem, directed[r].typed, directed[r].res);
        end
        foreach (fill_rows[r]) begin
            for (int k = 0; k < fill_rows[r].reps; k++) begin
                send_op(fill_rows[r].op, fill_rows[r].elem + k, fill_rows[r].typed,
                        fill_rows[r].res);
            end
        end

        // random: phases lean toward pushes or pops so both classes fill and empty
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n % 64 == 0) begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 80;
                    1:       push_pct = 25;
                    default: push_pct = 53;
                endcase
                hi_pct = $urandom_range(0, 100);
            end
            if (n == NUM_RANDOM / 2 || $urandom_range(0, 199) == 0) begin
                drain_results();
            end else if (burst_left == 0) begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                if (gap != 0) begin
                    i_s_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = $urandom_range(1, 24);
            end
            if (burst_left != 0) burst_left--;

            roll = $urandom_range(0, 99);
            if (roll < 2)
                op = OP_CLEAR;
            else if (roll < push_pct)
                op = ($urandom_range(0, 99) < hi_pct) ? OP_PUSH_HI : OP_PUSH_LO;
            else
                op = OP_POP;

            case ($urandom_range(0, 15))
                0:       elem = '0;
                1:       elem = '1;
                default: elem = $urandom();
            endcase
            send_op(op, elem, 1'b0, '{'0, 1'b0, ST_OK, 1'b0});
        end

        // let the last results come home, then idle the input and report the verdict
        drain_results();
        repeat (4) @(posedge i_clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
